### hw/rtl/nlt_pkg.sv
package nlt_pkg;

   localparam int LMAX = 9;
   localparam int LN   = LMAX + 1;
   localparam int CW   = 27;   // coefficient width, unsigned q.24

   localparam logic signed [31:0] P00_Q24 = 32'sd4732765;

   typedef logic [LN-1:0][CW-1:0]          nlt_row_type;
   typedef logic [LN-1:0][LN-1:0][CW-1:0]  nlt_grid_type;   // [order][degree]

   // neighbour link along the cell row
   typedef struct packed {
      logic              tok;
      logic              diag_vld;
      logic signed [31:0] diag;
   } nlt_link_type;

   // broadcast control from the top level
   typedef struct packed {
      logic load;
      logic adv;
   } nlt_ctrl_type;

   // elaboration-time long division, bit by bit
   function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned croot(longint unsigned v);
      longint unsigned res;
      longint unsigned rem;
      longint unsigned b;
      res = 0;
      rem = v;
      for (int k = 0; k < 32; k++) begin
         b = 64'd1 << (62 - 2 * k);
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [CW-1:0] ccoef(longint unsigned num, longint unsigned den);
      longint unsigned r;
      r = 0;
      if (den != 0) begin
         r = croot(cdiv(num << 48, den));
      end
      return r[CW-1:0];
   endfunction

   function automatic nlt_row_type build_cd();
      nlt_row_type row;
      row = '0;
      for (int m = 1; m <= LMAX; m++) begin
         row[m] = ccoef(longint'(2 * m + 1), longint'(2 * m));
      end
      return row;
   endfunction

   function automatic nlt_row_type build_c1();
      nlt_row_type row;
      row = '0;
      for (int m = 0; m <= LMAX; m++) begin
         row[m] = ccoef(longint'(2 * m + 3), 64'd1);
      end
      return row;
   endfunction

   function automatic nlt_grid_type build_ca();
      nlt_grid_type g;
      g = '0;
      for (int m = 0; m <= LMAX; m++) begin
         for (int l = m + 2; l <= LMAX; l++) begin
            g[m][l] = ccoef(longint'((2 * l + 1) * (2 * l - 1)),
                            longint'((l + m) * (l - m)));
         end
      end
      return g;
   endfunction

   function automatic nlt_grid_type build_cb();
      nlt_grid_type g;
      g = '0;
      for (int m = 0; m <= LMAX; m++) begin
         for (int l = m + 2; l <= LMAX; l++) begin
            g[m][l] = ccoef(longint'((2 * l + 1) * (l - m - 1) * (l + m - 1)),
                            longint'((2 * l - 3) * (l - m) * (l + m)));
         end
      end
      return g;
   endfunction

   localparam nlt_row_type  CD_ROW  = build_cd();
   localparam nlt_row_type  C1_ROW  = build_c1();
   localparam nlt_grid_type CA_GRID = build_ca();
   localparam nlt_grid_type CB_GRID = build_cb();

   // round to nearest, ties up: floor((p + 2^(k-1)) / 2^k)
   function automatic logic signed [39:0] rnd24(logic signed [63:0] p);
      logic signed [63:0] q;
      q = (p + 64'sd8388608) >>> 24;
      return q[39:0];
   endfunction

   function automatic logic signed [39:0] rnd15(logic signed [63:0] p);
      logic signed [63:0] q;
      q = (p + 64'sd16384) >>> 15;
      return q[39:0];
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/normalized_legendre_table_unit.sv
// normalised associated legendre table: each item on req is one argument x (a cosine,
// signed q1.15); the unit answers with every orthonormal value p(l,m) for
// 0 <= m <= l <= 9, 55 items on rsp, order m ascending then degree l ascending,
// value in signed q8.24 with saturation, tlast on the final value of the table.
// sqrt(1-x^2) comes from a bit-serial root unit that runs on the next argument
// while the current table is still streaming. the table itself is built by
// a row of ten cells, one per order m: the diagonal term ripples from cell to cell,
// and the cell holding the token runs the three-term recurrence in l, one value a
// cycle while rsp does not stall. tables follow each other once the next argument
// is loaded into the cell row; an rsp stall holds the stepping cell and the token,
// while the diagonal ripple goes on.
module normalized_legendre_table_unit
   import nlt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] x
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] degree, [7:4] order, [39:8] value
   output logic        rsp_tlast
);

   logic               root_valid;
   logic               root_take;
   logic signed [15:0] root_x;
   logic [24:0]        root_s;

   logic signed [15:0] x_ff;
   logic [24:0]        s_ff;
   logic               run_ff, run_in;
   logic               go_ff;
   logic               fin;

   logic               rsp_valid_ff;
   logic [39:0]        rsp_data_ff;
   logic               rsp_last_ff;

   nlt_ctrl_type       ctrl;
   nlt_link_type       link [LN+1];
   logic [LN-1:0]      act_vec;
   logic [3:0]         deg_vec [LN];
   logic signed [31:0] val_vec [LN];

   logic [3:0]         sel_deg;
   logic [3:0]         sel_ord;
   logic signed [31:0] sel_val;
   logic               any_act;

   // sqrt(1 - x^2) unit, with its own input stage
   nlt_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (signed'(req_tdata)),
      .res_valid (root_valid),
      .res_take  (root_take),
      .res_x     (root_x),
      .res_s     (root_s)
   );

   // next argument enters the cell row once the previous table is on its last value
   assign fin       = link[LN].tok;
   assign root_take = root_valid && (!run_ff || fin);
   assign ctrl.adv  = !rsp_valid_ff || rsp_tready;
   assign ctrl.load = root_take;

   always_comb begin
      run_in = run_ff;
      if (root_take) begin
         run_in = 1'b1;
      end else if (fin) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         go_ff  <= 1'b0;
      end else begin
         run_ff <= run_in;
         go_ff  <= root_take;
      end
      if (root_take) begin
         x_ff <= root_x;
         s_ff <= root_s;
      end
   end

   // the first cell starts from p(0,0) and takes the token when the row is loaded
   assign link[0].tok      = go_ff;
   assign link[0].diag_vld = go_ff;
   assign link[0].diag     = P00_Q24;

   for (genvar m = 0; m < LN; m++) begin : g_cell
      nlt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_order (4'(m)),
         .ctrl       (ctrl),
         .x          (x_ff),
         .s          (s_ff),
         .link_in    (link[m]),
         .link_out   (link[m+1]),
         .active     (act_vec[m]),
         .degree     (deg_vec[m]),
         .value      (val_vec[m])
      );
   end

   // at most one cell holds the token, so an or of masked outputs selects it
   always_comb begin
      sel_deg = '0;
      sel_ord = '0;
      sel_val = '0;
      for (int m = 0; m < LN; m++) begin
         if (act_vec[m]) begin
            sel_deg = sel_deg | deg_vec[m];
            sel_ord = sel_ord | 4'(m);
            sel_val = sel_val | val_vec[m];
         end
      end
   end

   assign any_act = |act_vec;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.adv) begin
         rsp_valid_ff <= any_act;
      end
      if (ctrl.adv) begin
         rsp_data_ff <= {sel_val, sel_ord, sel_deg};
         rsp_last_ff <= act_vec[LMAX];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // only one cell may stream at a time
   a_one_active : assert property (@(posedge clock) disable iff (reset)
      $onehot0(act_vec))
      else $error("more than one cell active");

   // a new argument is loaded only when no column other than the last is in flight
   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      root_take |-> (act_vec[LMAX-1:0] == '0))
      else $error("argument loaded while the table is streaming");

   // the table finishes only while a run is open
   a_fin_run : assert property (@(posedge clock) disable iff (reset)
      fin |-> run_ff)
      else $error("table end outside a run");

   // the start token follows a load in the next cycle
   a_go_load : assert property (@(posedge clock) disable iff (reset)
      root_take |=> go_ff && run_ff)
      else $error("start token lost after load");

endmodule

### hw/rtl/nlt_root.sv
module nlt_root
   import nlt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [15:0] in_x,
   output logic               res_valid,
   input  logic               res_take,
   output logic signed [15:0] res_x,
   output logic [24:0]        res_s
);

   logic               q_vld_ff, q_vld_in;
   logic signed [15:0] q_x_ff, q_x_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [49:0]        rem_ff, rem_in;
   logic [49:0]        res_ff, res_in;
   logic [49:0]        bit_ff, bit_in;
   logic signed [15:0] xc_ff, xc_in;
   logic               start;
   logic signed [31:0] xx;
   logic [30:0]        v;
   logic [49:0]        trial;

   assign start    = q_vld_ff && !busy_ff && (!done_ff || res_take);
   assign in_ready = !q_vld_ff || start;
   assign xx       = q_x_ff * q_x_ff;
   assign v        = 31'(32'sd1073741824 - xx);
   assign trial    = res_ff + bit_ff;

   always_comb begin
      q_vld_in = q_vld_ff;
      q_x_in   = q_x_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      xc_in    = xc_ff;
      if (res_take) begin
         done_in = 1'b0;
      end
      if (start) begin
         q_vld_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         q_vld_in = 1'b1;
         q_x_in   = in_x;
      end
      if (busy_ff) begin
         // one root bit a cycle
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd24) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, v, 18'd0};
         res_in  = '0;
         bit_in  = 50'd1 << 48;
         xc_in   = q_x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         q_vld_ff <= q_vld_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      q_x_ff <= q_x_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      xc_ff  <= xc_in;
   end

   assign res_valid = done_ff;
   assign res_x     = xc_ff;
   assign res_s     = res_ff[24:0];

endmodule

### hw/rtl/nlt_cell.sv
module nlt_cell
   import nlt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [3:0]         cell_order,
   input  nlt_ctrl_type       ctrl,
   input  logic signed [15:0] x,
   input  logic [24:0]        s,
   input  nlt_link_type       link_in,
   output nlt_link_type       link_out,
   output logic               active,
   output logic [3:0]         degree,
   output logic signed [31:0] value
);

   logic               active_ff, active_in;
   logic [3:0]         l_ff, l_in;
   logic signed [31:0] p1_ff, p2_ff;
   logic signed [31:0] diag_ff, diag_in;
   logic               diag_vld_ff, diag_vld_in;
   logic signed [26:0] td_ff;
   logic signed [28:0] t1_ff;
   logic signed [28:0] ap_ff;
   logic               step;
   logic               at_end;
   logic signed [39:0] r_td, r_t1, r_ap, r_diag, r_one, r_a, r_b;
   logic [51:0]        m_td;
   logic signed [43:0] m_t1, m_ap;
   logic signed [58:0] m_diag;
   logic signed [60:0] m_one;
   logic signed [60:0] m_a;
   logic signed [59:0] m_b;

   assign step   = active_ff && ctrl.adv;
   assign at_end = (l_ff == 4'(LMAX));

   always_comb begin
      l_in = l_ff;
      if (link_in.tok) begin
         l_in = cell_order;
      end else if (step && !at_end) begin
         l_in = l_ff + 4'd1;
      end
   end

   // coefficient products, refreshed every cycle from the held sample
   assign m_td = CD_ROW[cell_order] * s;
   assign r_td = rnd24(64'(m_td));
   assign m_t1 = signed'({1'b0, C1_ROW[cell_order]}) * x;
   assign r_t1 = rnd15(64'(m_t1));
   assign m_ap = signed'({1'b0, CA_GRID[cell_order][l_in]}) * x;
   assign r_ap = rnd15(64'(m_ap));

   // diagonal hand-off from the left neighbour
   assign m_diag = td_ff * link_in.diag;
   assign r_diag = rnd24(64'(m_diag));

   always_comb begin
      diag_vld_in = diag_vld_ff;
      diag_in     = diag_ff;
      if (ctrl.load) begin
         diag_vld_in = 1'b0;
      end else if (link_in.diag_vld && !diag_vld_ff) begin
         diag_vld_in = 1'b1;
         if (cell_order == 4'd0) begin
            diag_in = link_in.diag;
         end else begin
            diag_in = sat32(-r_diag);
         end
      end
   end

   // column recurrence in degree
   assign m_one = t1_ff * p1_ff;
   assign r_one = rnd24(64'(m_one));
   assign m_a   = ap_ff * p1_ff;
   assign r_a   = rnd24(64'(m_a));
   assign m_b   = signed'({1'b0, CB_GRID[cell_order][l_ff]}) * p2_ff;
   assign r_b   = rnd24(64'(m_b));

   always_comb begin
      if (l_ff == cell_order) begin
         value = diag_ff;
      end else if (l_ff == cell_order + 4'd1) begin
         value = sat32(r_one);
      end else begin
         value = sat32(r_a - r_b);
      end
   end

   always_comb begin
      active_in = active_ff;
      if (link_in.tok) begin
         active_in = 1'b1;
      end else if (step && at_end) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         diag_vld_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         diag_vld_ff <= diag_vld_in;
      end
      l_ff    <= l_in;
      diag_ff <= diag_in;
      td_ff   <= r_td[26:0];
      t1_ff   <= r_t1[28:0];
      ap_ff   <= r_ap[28:0];
      if (step) begin
         p2_ff <= p1_ff;
         p1_ff <= value;
      end
   end

   assign link_out.tok      = step && at_end;
   assign link_out.diag_vld = diag_vld_ff;
   assign link_out.diag     = diag_ff;
   assign active            = active_ff;
   assign degree            = l_ff;

endmodule

### bench/tb.sv
module tb
   import nlt_pkg::*;
();

   localparam string PASS_MSG = "Test completed successfully";
   localparam string FAIL_MSG = "Test completed with failures";
   localparam int    WATCHDOG_LIMIT = 20000;
   localparam int    N_RANDOM = 450;
   localparam int    HOLD_OFF_CYCLES = 400;

   // one table value as seen on rsp
   typedef struct packed {
      logic [3:0]         degree;
      logic [3:0]         order;
      logic signed [31:0] value;
      logic               last;
   } table_value_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] x
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [3:0] degree, [7:4] order, [39:8] value
   logic        rsp_tlast;

   normalized_legendre_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // arguments waiting to be sent, and table values still owed by the unit
   logic [15:0]     pending_args[$];
   table_value_type owed_values[$];

   int  error_count = 0;
   int  args_taken = 0;
   int  values_seen = 0;
   int  idle_cycles;
   int  send_idle_pct = 0;     // chance in a hundred that the sender idles
   int  recv_stall_pct = 0;    // chance in a hundred that the receiver stalls
   int  hold_off_left;         // long receiver hold-off, counted down in the receiver
   bit  hold_off_req = 1'b0;   // asks the receiver for its long hold-off
   bit  hold_off_armed;        // the hold-off has been started
   bit  pause_sender = 1'b0;   // sender waits for the table to drain

   // ------------------------------------------------------------------
   // predictor: integer square root, 32 steps over a 64-bit radicand
   // ------------------------------------------------------------------
   function automatic longint unsigned isqrt64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      for (int k = 0; k < 32; k++) begin
         b = 64'd1 << (62 - 2 * k);
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // rom coefficient sqrt(n/d) in unsigned q.24
   function automatic longint coef_q24(longint unsigned n, longint unsigned d);
      if (d == 0) begin
         return 0;
      end
      return longint'(isqrt64((n << 48) / d));
   endfunction

   // round to nearest, ties toward +inf; >>> is a floor on signed values
   function automatic longint round_drop(longint p, int k);
      return (p + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_q824(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // builds the whole table for one argument and queues it in output order
   task automatic predict_table(logic [15:0] x_raw);
      longint tab[LN][LN];   // [degree][order]
      longint xs, s, t, a, b, ca, cb;
      table_value_type tv;
      xs = longint'($signed(x_raw));
      s  = longint'(isqrt64(longint'(64'sd1073741824 - xs * xs) << 18));
      tab[0][0] = 4732765;
      // diagonal terms, through sqrt(1-x^2)
      for (int m = 1; m <= LMAX; m++) begin
         t = coef_q24(2 * m + 1, 2 * m);
         t = round_drop(t * s, 24);
         tab[m][m] = clamp_q824(-round_drop(t * tab[m-1][m-1], 24));
      end
      // first off-diagonal terms
      for (int m = 0; m < LMAX; m++) begin
         t = coef_q24(2 * m + 3, 1);
         t = round_drop(t * xs, 15);
         tab[m+1][m] = clamp_q824(round_drop(t * tab[m][m], 24));
      end
      // three-term recurrence in degree
      for (int m = 0; m <= LMAX; m++) begin
         for (int l = m + 2; l <= LMAX; l++) begin
            ca = coef_q24((2 * l + 1) * (2 * l - 1), (l + m) * (l - m));
            cb = coef_q24((2 * l + 1) * (l - m - 1) * (l + m - 1),
                          (2 * l - 3) * (l - m) * (l + m));
            a  = round_drop(ca * xs, 15);
            a  = round_drop(a * tab[l-1][m], 24);
            b  = round_drop(cb * tab[l-2][m], 24);
            tab[l][m] = clamp_q824(a - b);
         end
      end
      for (int m = 0; m <= LMAX; m++) begin
         for (int l = m; l <= LMAX; l++) begin
            tv.degree = 4'(l);
            tv.order  = 4'(m);
            tv.value  = 32'(tab[l][m]);
            tv.last   = (m == LMAX && l == LMAX);
            owed_values.push_back(tv);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // driver: offers queued arguments on req, idling at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         // item taken at this edge, or nothing was on offer
         if (!req_tvalid || req_tready) begin
            if (pending_args.size() != 0 && !pause_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_args.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // prediction on every accepted argument
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_table(req_tdata);
         args_taken <= args_taken + 1;
      end
   end

   // ------------------------------------------------------------------
   // receiver: rsp_tready with random stalls and one long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         hold_off_left  <= 0;
         hold_off_armed <= 1'b0;
      end else if (hold_off_req && !hold_off_armed) begin
         rsp_tready     <= 1'b0;
         hold_off_left  <= HOLD_OFF_CYCLES;
         hold_off_armed <= 1'b1;
      end else if (hold_off_left > 0) begin
         rsp_tready    <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // monitor: compares each accepted value with the oldest owed one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      table_value_type exp_v;
      bit              bad;
      bad = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         values_seen <= values_seen + 1;
         if (owed_values.size() == 0) begin
            $error("unexpected item on rsp: data %h last %b", rsp_tdata, rsp_tlast);
            bad = 1'b1;
         end else begin
            exp_v = owed_values.pop_front();
            if (rsp_tdata[3:0] !== exp_v.degree) begin
               $error("degree: expected %0d, got %0d", exp_v.degree, rsp_tdata[3:0]);
               bad = 1'b1;
            end
            if (rsp_tdata[7:4] !== exp_v.order) begin
               $error("order: expected %0d, got %0d", exp_v.order, rsp_tdata[7:4]);
               bad = 1'b1;
            end
            if (rsp_tdata[39:8] !== exp_v.value) begin
               $error("value (l=%0d m=%0d): expected %0d, got %0d", exp_v.degree,
                      exp_v.order, exp_v.value, $signed(rsp_tdata[39:8]));
               bad = 1'b1;
            end
            if (rsp_tlast !== exp_v.last) begin
               $error("last: expected %b, got %b", exp_v.last, rsp_tlast);
               bad = 1'b1;
            end
         end
         if (bad) begin
            error_count <= error_count + 1;
         end
      end
   end

   // watchdog: cycles in which neither side moves an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress in %0d cycles", WATCHDOG_LIMIT);
            $display("%s", FAIL_MSG);
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus and phase control
   // ------------------------------------------------------------------
   task automatic wait_drained();
      while (pending_args.size() != 0 || req_tvalid || owed_values.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // random argument: mostly uniform, some near the ends and zero
   function automatic logic [15:0] random_arg();
      case ($urandom_range(9))
         0: return 16'h8000 + 16'($urandom_range(15));
         1: return 16'h7fff - 16'($urandom_range(15));
         2: return 16'($signed($urandom_range(32)) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int per_phase;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: the argument -1 (no diagonal past p(0,0)), the top end, zero,
      // tiny magnitudes, single-bit patterns and the region near |x| = 1
      pending_args.push_back(16'h8000);
      pending_args.push_back(16'h7fff);
      pending_args.push_back(16'h0000);
      pending_args.push_back(16'h0001);
      pending_args.push_back(16'hffff);
      pending_args.push_back(16'h8001);
      pending_args.push_back(16'h7ffe);
      pending_args.push_back(16'h4000);
      pending_args.push_back(16'hc000);
      pending_args.push_back(16'h5555);
      pending_args.push_back(16'haaaa);
      pending_args.push_back(16'h2000);
      pending_args.push_back(16'h6ed9);   // about cos(30 deg)
      pending_args.push_back(16'h0100);
      wait_drained();

      // random phases: free flow, sender idle, receiver stall, both
      per_phase = N_RANDOM / 4;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 26 : 0;
         recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 26 : 0;
         for (int i = 0; i < per_phase; i++) begin
            pending_args.push_back(random_arg());
         end
         if (ph == 0) begin
            // long receiver hold-off while arguments keep coming, so req stalls
            repeat (20) @(posedge clock);
            hold_off_req <= 1'b1;
         end
         if (ph == 2) begin
            // sender stops until the unit has emptied, then resumes
            while (pending_args.size() > per_phase / 2) @(posedge clock);
            pause_sender <= 1'b1;
            while (owed_values.size() != 0 || req_tvalid) @(posedge clock);
            pause_sender <= 1'b0;
         end
         wait_drained();
      end

      // allow any trailing item from the unit to show up
      repeat (200) @(posedge clock);

      $display("covered %0d arguments and %0d table values, including x = -1, the",
               args_taken, values_seen);
      $display("top of range, zero, and flow with sender gaps and receiver stalls");
      if (error_count == 0) begin
         $display("%s", PASS_MSG);
      end else begin
         $display("%s", FAIL_MSG);
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/nlt_pkg.sv
hw/rtl/nlt_root.sv
hw/rtl/nlt_cell.sv
hw/rtl/normalized_legendre_table_unit.sv
bench/tb.sv
